// ===== design/nfa_pkg.sv =====
`timescale 1ns / 1ps

package nfa_pkg;

	// Fixed field widths of the item and configuration formats.
	localparam int STATE_IDX_W = 5;
	localparam int SYMBOL_W    = 8;
	localparam int SET_W       = 32;
	localparam int CNT_W       = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;

	// Item modes.
	localparam logic [1:0] MODE_WRITE  = 2'd0;
	localparam logic [1:0] MODE_START  = 2'd1;
	localparam logic [1:0] MODE_SYMBOL = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_SET  = 1'b1;

	typedef struct packed {
		logic [1:0]             mode;
		logic [STATE_IDX_W-1:0] source_state;
		logic [SYMBOL_W-1:0]    symbol;
		logic [SET_W-1:0]       next_set;
	} in_item_t;

	typedef struct packed {
		logic             accepted;
		logic [CNT_W-1:0] position;
		logic             set_empty;
		logic [CNT_W-1:0] steps_taken;
	} out_item_t;

endpackage

// ===== design/nfa_set_simulation_matcher.sv =====
`timescale 1ns / 1ps

// NFA state-set matcher with epsilon closure.
// Input channel (in_valid/in_ready/in_data) carries write, start and symbol
// items; output channel (out_valid/out_ready/out_data) carries one result per
// start or symbol item. Configuration (start state, accepting set) is written
// through cfg_we/cfg_index/cfg_data, by the user only while the block is idle;
// the block does not enforce this. One item is in work at a time. A start item
// runs R epsilon closure rounds, a symbol item a move step (if any state is
// active) and then R rounds; the R (1 to STATE_COUNT) rounds run one per
// cycle over the registered epsilon rows; the symbol's move row comes from
// one wide read of the transition memory (one word per symbol holding every
// state's row). The result is held in an output register; the next item is
// taken while it waits. If a result is still untaken when the next one is
// ready, the block waits in its closure state until the output register
// frees. After reset the transition memory is swept to zero, one word per
// cycle, during which no item is taken; configuration writes are taken
// throughout. Reset also clears the active set and counters.
module nfa_set_simulation_matcher import nfa_pkg::*; #(
	parameter int STATE_COUNT = 32,
	parameter int SYMBOL_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SC       = STATE_COUNT;
	localparam int IW       = (SC > 1) ? $clog2(SC) : 1;
	localparam int DEPTH    = 1 << SYMBOL_BITS;
	localparam int WORD_W   = SC * SC;

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_MOVE, ST_CLOSE} state_t;

	state_t                 state_q;
	logic [SYMBOL_BITS-1:0] clr_q;
	logic [SC-1:0]          active_q;
	logic [SC-1:0]          cur_q;
	logic [SC-1:0]          eps_q [SC];
	logic [CNT_W-1:0]       posctr_q;
	logic [CNT_W-1:0]       pos_q;
	logic [CNT_W-1:0]       step_q;
	logic [STATE_IDX_W-1:0] start_q;
	logic [SET_W-1:0]       accept_q;
	logic                   out_valid_q;
	out_item_t              out_data_q;

	logic [WORD_W-1:0]      mem [DEPTH];
	logic [WORD_W-1:0]      rd_word_s1;

	logic                   in_xfer;
	logic [SYMBOL_BITS-1:0] sym_idx;
	logic [IW-1:0]          src_idx;
	logic                   src_ok;
	logic                   mem_we;
	logic [SC-1:0]          wr_row;
	logic [SC-1:0]          move_set;
	logic [SC-1:0]          eps_union;
	logic [SC-1:0]          nxt_set;
	logic [SC-1:0]          start_set;
	logic                   out_free;
	logic                   res_load;

	// Decoding of the item at the input.
	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign sym_idx  = in_data.symbol[SYMBOL_BITS-1:0];
	assign src_idx  = IW'(in_data.source_state);
	assign src_ok   = int'(in_data.source_state) < SC;
	assign mem_we   = in_xfer && (in_data.mode == MODE_WRITE) && src_ok;
	assign wr_row   = SC'(in_data.next_set);
	assign out_free = !out_valid_q || out_ready;

	// Union of the rows of the active states taken from the wide memory word.
	always_comb begin
		move_set = '0;
		for (int s = 0; s < SC; s++) begin
			if (active_q[s]) begin
				move_set = move_set | rd_word_s1[s*SC +: SC];
			end
		end
	end

	// One epsilon closure round over the registered epsilon rows.
	always_comb begin
		eps_union = '0;
		for (int s = 0; s < SC; s++) begin
			if (cur_q[s]) begin
				eps_union = eps_union | eps_q[s];
			end
		end
		nxt_set = cur_q | eps_union;
	end

	// The closure has settled and the output register can take the result.
	assign res_load = (state_q == ST_CLOSE) && (nxt_set == cur_q) && out_free;

	// Start set: the start state alone, or empty when it is out of range.
	always_comb begin
		start_set = '0;
		if (int'(start_q) < SC) begin
			start_set[IW'(start_q)] = 1'b1;
		end
	end

	// Transition memory: one word per symbol, one row slice per source state.
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			mem[clr_q] <= '0;
		end else if (mem_we) begin
			mem[sym_idx][int'(src_idx)*SC +: SC] <= wr_row;
		end
		rd_word_s1 <= mem[sym_idx];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			accept_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_STATE: start_q  <= cfg_data[STATE_IDX_W-1:0];
				CFG_ACCEPT_SET:  accept_q <= cfg_data[SET_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, run state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			active_q    <= '0;
			cur_q       <= '0;
			posctr_q    <= '0;
			pos_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			for (int s = 0; s < SC; s++) begin
				eps_q[s] <= '0;
			end
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						unique case (in_data.mode)
							MODE_WRITE: begin
								if (src_ok && sym_idx == '0) begin
									eps_q[src_idx] <= wr_row;
								end
							end
							MODE_START: begin
								cur_q    <= start_set;
								pos_q    <= '0;
								posctr_q <= '0;
								step_q   <= '0;
								state_q  <= ST_CLOSE;
							end
							MODE_SYMBOL: begin
								pos_q <= posctr_q;
								if (posctr_q != '1) begin
									posctr_q <= posctr_q + 1'b1;
								end
								if (active_q != '0) begin
									if (step_q != '1) begin
										step_q <= step_q + 1'b1;
									end
									state_q <= ST_MOVE;
								end else begin
									cur_q   <= '0;
									state_q <= ST_CLOSE;
								end
							end
							default: ;
						endcase
					end
				end
				ST_MOVE: begin
					cur_q   <= move_set;
					state_q <= ST_CLOSE;
				end
				ST_CLOSE: begin
					if (nxt_set != cur_q) begin
						cur_q <= nxt_set;
					end else if (out_free) begin
						active_q               <= cur_q;
						out_data_q.accepted    <= (cur_q & SC'(accept_q)) != '0;
						out_data_q.position    <= pos_q;
						out_data_q.set_empty   <= (cur_q == '0);
						out_data_q.steps_taken <= step_q;
						state_q                <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTH
	// No item is taken while the memory sweep runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("item taken during memory clearing");

	// A closure round only ever adds states.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLOSE && nxt_set != cur_q) |=>
			((cur_q & $past(cur_q)) == $past(cur_q)))
		else $error("closure round lost a state");

	// An empty set can never be reported as accepting.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.set_empty && out_data.accepted))
		else $error("empty set reported as accepting");

	// A result is only produced when the output register is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("pending result overwritten");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import nfa_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_START_STATE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	nfa_set_simulation_matcher dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Clock generation.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted matcher state, kept alongside the block.
	logic [SET_W-1:0] nfa_rows [32][256];
	logic [SET_W-1:0] live_set = '0;
	logic [CNT_W-1:0] sym_pos = '0;
	logic [CNT_W-1:0] live_steps = '0;
	logic [STATE_IDX_W-1:0] start_reg = '0;
	logic [SET_W-1:0] accept_reg = '0;

	out_item_t expected_results [$];
	in_item_t pending_items [$];
	int items_queued = 0;
	int items_taken = 0;
	int results_seen = 0;
	int rows_written = 0;
	int runs_started = 0;
	int symbols_fed = 0;
	int errors = 0;

	// Close a state set under the epsilon rows until it stops growing.
	function automatic logic [SET_W-1:0] eps_close(logic [SET_W-1:0] s);
		logic [SET_W-1:0] prev;
		logic [SET_W-1:0] acc;
		do begin
			prev = s;
			acc = '0;
			for (int i = 0; i < 32; i++)
				if (s[i])
					acc |= nfa_rows[i][0];
			s |= acc;
		end while (s != prev);
		return s;
	endfunction

	// Advance the predicted state by one item and queue any result it causes.
	task automatic predict_item(in_item_t it);
		out_item_t r;
		logic [SET_W-1:0] moved;
		logic [CNT_W-1:0] pos;
		if (it.mode == MODE_WRITE) begin
			nfa_rows[it.source_state][it.symbol] = it.next_set;
			rows_written++;
		end else if (it.mode == MODE_START || it.mode == MODE_SYMBOL) begin
			pos = '0;
			if (it.mode == MODE_START) begin
				live_set = eps_close(SET_W'(1) << start_reg);
				sym_pos = '0;
				live_steps = '0;
				runs_started++;
			end else begin
				pos = sym_pos;
				if (sym_pos != 16'hFFFF)
					sym_pos++;
				if (live_set != '0) begin
					moved = '0;
					for (int i = 0; i < 32; i++)
						if (live_set[i])
							moved |= nfa_rows[i][it.symbol];
					live_set = eps_close(moved);
					if (live_steps != 16'hFFFF)
						live_steps++;
				end
				symbols_fed++;
			end
			r.accepted = (live_set & accept_reg) != '0;
			r.position = pos;
			r.set_empty = live_set == '0;
			r.steps_taken = live_steps;
			expected_results.push_back(r);
		end
	endtask

	// Sender: bursts of transfers separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready) begin
				predict_item(in_data);
				items_taken++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= pending_items.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 30);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each transfer and stalls on its own pattern, with one
	// long hold-off so that the block backs up onto its input.
	int stall_pct = 0;
	int pattern_cycles = 0;
	int hold_left = 0;
	bit hold_done = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					out_item_t e;
					e = expected_results.pop_front();
					if (out_data.accepted !== e.accepted) begin
						$error("accepted: expected %0d, got %0d", e.accepted, out_data.accepted);
						errors++;
					end
					if (out_data.position !== e.position) begin
						$error("position: expected %0d, got %0d", e.position, out_data.position);
						errors++;
					end
					if (out_data.set_empty !== e.set_empty) begin
						$error("set_empty: expected %0d, got %0d", e.set_empty,
							out_data.set_empty);
						errors++;
					end
					if (out_data.steps_taken !== e.steps_taken) begin
						$error("steps_taken: expected %0d, got %0d", e.steps_taken,
							out_data.steps_taken);
						errors++;
					end
				end
			end
			if (!hold_done && results_seen >= 150) begin
				hold_done = 1;
				hold_left = 2000;
			end
			if (pattern_cycles == 0) begin
				pattern_cycles = $urandom_range(50, 400);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 20;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end else begin
				pattern_cycles--;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	function automatic in_item_t make_item(logic [1:0] m, logic [4:0] src, logic [7:0] sym,
		logic [31:0] set);
		in_item_t it;
		it.mode = m;
		it.source_state = src;
		it.symbol = sym;
		it.next_set = set;
		return it;
	endfunction

	task automatic queue_item(in_item_t it);
		pending_items.push_back(it);
		items_queued++;
	endtask

	// Symbols mostly from a tiny alphabet so that written rows get used.
	function automatic logic [7:0] pick_symbol();
		if ($urandom_range(0, 9) < 8)
			return 8'($urandom_range(0, 3));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [31:0] sparse_set();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return $urandom();
			default: return $urandom() & $urandom() & $urandom();
		endcase
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_START_STATE)
			start_reg = val[STATE_IDX_W-1:0];
		else
			accept_reg = val;
	endtask

	// Wait until every item has been taken and every result has come back,
	// then allow for a write item still in work.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (items_taken != items_queued || expected_results.size() != 0);
		repeat (40) @(posedge clk);
	endtask

	// Stimulus and end of run.
	initial begin
		for (int s = 0; s < 32; s++)
			for (int y = 0; y < 256; y++)
				nfa_rows[s][y] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(CFG_START_STATE, 32'd0);
		write_reg(CFG_ACCEPT_SET, 32'h8000_0000);

		// Directed: epsilon chains, extreme states, symbols and sets.
		queue_item(make_item(MODE_START, 5'd0, 8'd0, '0));
		queue_item(make_item(MODE_SYMBOL, 5'd0, 8'd5, '0));
		queue_item(make_item(MODE_SYMBOL, 5'd0, 8'd5, '0));
		queue_item(make_item(MODE_WRITE, 5'd0, 8'd0, 32'h0000_0002));
		queue_item(make_item(MODE_WRITE, 5'd1, 8'd0, 32'h8000_0000));
		queue_item(make_item(MODE_WRITE, 5'd31, 8'd255, 32'hFFFF_FFFF));
		queue_item(make_item(MODE_WRITE, 5'd31, 8'd0, 32'h0000_0001));
		queue_item(make_item(MODE_WRITE, 5'd2, 8'd1, 32'h0000_0000));
		queue_item(make_item(2'd3, 5'd31, 8'd255, 32'hFFFF_FFFF));
		queue_item(make_item(MODE_START, 5'd31, 8'd255, 32'hFFFF_FFFF));
		queue_item(make_item(MODE_SYMBOL, 5'd0, 8'd255, '0));
		queue_item(make_item(MODE_SYMBOL, 5'd0, 8'd0, '0));
		queue_item(make_item(MODE_SYMBOL, 5'd0, 8'd1, '0));
		queue_item(make_item(MODE_SYMBOL, 5'd0, 8'd7, '0));
		queue_item(make_item(MODE_SYMBOL, 5'd0, 8'd255, '0));
		queue_item(make_item(MODE_START, 5'd0, 8'd0, '0));
		queue_item(make_item(MODE_SYMBOL, 5'd0, 8'd255, '0));
		queue_item(make_item(MODE_WRITE, 5'd31, 8'd0, 32'h0000_0000));
		wait_idle();

		// Random phases, each under a different register setting.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin write_reg(CFG_START_STATE, 32'd31);
					write_reg(CFG_ACCEPT_SET, 32'hFFFF_FFFF); end
				1: begin write_reg(CFG_START_STATE, 32'd0);
					write_reg(CFG_ACCEPT_SET, 32'h0); end
				default: begin write_reg(CFG_START_STATE, $urandom_range(0, 31));
					write_reg(CFG_ACCEPT_SET, $urandom()); end
			endcase
			for (int n = 0; n < 120;) begin
				if ($urandom_range(0, 9) < 7) begin
					int w;
					int k;
					w = $urandom_range(1, 8);
					k = $urandom_range(1, 20);
					for (int i = 0; i < w; i++)
						queue_item(make_item(MODE_WRITE, 5'($urandom_range(0, 31)),
							pick_symbol(), sparse_set()));
					queue_item(make_item(MODE_START, 5'($urandom()), 8'($urandom()),
						$urandom()));
					for (int i = 0; i < k; i++)
						queue_item(make_item(MODE_SYMBOL, 5'($urandom()), pick_symbol(),
							$urandom()));
					n += w + k + 1;
				end else begin
					queue_item(make_item(2'($urandom_range(0, 3)), 5'($urandom()),
						8'($urandom()), $urandom()));
					n++;
				end
			end
			wait_idle();
		end

		// Short run with a self-loop and no epsilon moves: the set stays
		// alive, then empties, and position keeps advancing while the step
		// count holds.
		write_reg(CFG_START_STATE, 32'd0);
		write_reg(CFG_ACCEPT_SET, 32'h0000_0001);
		for (int s = 0; s < 32; s++)
			queue_item(make_item(MODE_WRITE, 5'(s), 8'd0, '0));
		queue_item(make_item(MODE_WRITE, 5'd0, 8'h55, 32'h0000_0001));
		queue_item(make_item(MODE_WRITE, 5'd0, 8'h56, 32'h0000_0000));
		queue_item(make_item(MODE_START, 5'd0, 8'd0, '0));
		for (int i = 0; i < 24; i++)
			queue_item(make_item(MODE_SYMBOL, 5'd0, 8'h55, '0));
		queue_item(make_item(MODE_SYMBOL, 5'd0, 8'h56, '0));
		queue_item(make_item(MODE_SYMBOL, 5'd0, 8'h55, '0));
		queue_item(make_item(MODE_SYMBOL, 5'd0, 8'h55, '0));
		wait_idle();

		repeat (50) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			errors++;
		end
		$display("Covered %0d items: %0d row writes, %0d runs started, %0d symbols consumed,",
			items_taken, rows_written, runs_started, symbols_fed);
		$display("%0d results checked, including runs that empty and a long output stall.",
			results_seen);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#30ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== files.f =====
design/nfa_pkg.sv
design/nfa_set_simulation_matcher.sv
tb/sv/testbench.sv
